@@ rtl/tfrt_pkg.sv @@
// Package of the TCP flow reassembly table: states, status codes, defaults
// and the overlap policy constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfrt_pkg;

    localparam int DEF_SLOTS        = 64;
    localparam int DEF_BUFFER_BYTES = 2048;

    localparam logic [11:0] LIMIT_RESET = 12'd2048;
    localparam logic [6:0]  SLOTS_RESET = 7'd64;

    localparam logic [7:0]  TTL_LINUX_MAX = 8'd64;
    localparam logic [15:0] WIN_LINUX     = 16'd5840;
    localparam logic [15:0] WIN_WIN_A     = 16'd65535;
    localparam logic [15:0] WIN_WIN_B     = 16'd64240;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TBL_FULL  = 3'd1,
        ST_NO_FLOW   = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TOO_BIG   = 3'd4,
        ST_NO_SEG    = 3'd5,
        ST_PAST_FILL = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PRB_RD,
        S_PRB_CMP,
        S_OPEN,
        S_CLEAR,
        S_HDR_A,
        S_HDR_B,
        S_PAY_RD,
        S_PAY_WR,
        S_RD_CHK,
        S_RD_DATA
    } state_t;

    localparam logic [0:0] REG_LIMIT = 1'b0;
    localparam logic [0:0] REG_SLOTS = 1'b1;

endpackage

`default_nettype wire

@@ rtl/tfrt_mod_unit.sv @@
// Iterative remainder unit: 32-bit dividend mod a narrow divisor, one bit
// per cycle (restoring). Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module tfrt_mod_unit #(
    parameter int NW = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [31:0]   dividend,
    input  wire logic [NW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      remainder
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [31:0]   dvd_reg, dvd_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW:0]   shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[31]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, divisor}) begin
                rem_next = NW'(shifted - {1'b0, divisor});
            end else begin
                rem_next = NW'(shifted);
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/tcp_flow_reassembly_table_unit.sv @@
// Top level of the TCP flow reassembly table: sequencer, flow table and
// byte buffer. Depends on tfrt_pkg and tfrt_mod_unit.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken at a time; s_tready is high only when the sequencer is
// idle and the result register is empty. A payload byte passes two
// registered memory reads, then the write and the result. A read item or
// header first computes the hash remainder (one bit per cycle), then probes
// slots in S_PRB_RD alone for an open or in S_PRB_RD and S_PRB_CMP for a
// lookup. Opening a flow, or a data header that overflows the flow buffer,
// adds a clearing sweep over that flow's BUFFER_BYTES bytes. After reset a
// sweep over all SLOTS*BUFFER_BYTES entries (131072 by default) zeroes the
// buffer before the first transaction is accepted; register writes are
// taken meanwhile.
module tcp_flow_reassembly_table_unit #(
    parameter int SLOTS        = tfrt_pkg::DEF_SLOTS,
    parameter int BUFFER_BYTES = tfrt_pkg::DEF_BUFFER_BYTES
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // src_addr, dst_addr, src_port, dst_port, seq_num, tcp_flags, ip_ttl,
    // window_size, payload_len, payload_byte, read_offset
    input  wire logic [191:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, slot_index, fill_count, data_byte, first_wins, zero pad
    output logic [31:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = $clog2(SLOTS + 1);
    localparam int PW    = $clog2(BUFFER_BYTES + 1);
    localparam int DEPTH = SLOTS * BUFFER_BYTES;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic [31:0]   saddr;
        logic [31:0]   daddr;
        logic [15:0]   sport;
        logic [15:0]   dport;
        logic [31:0]   start;
        logic          policy;
        logic [PW-1:0] fill;
    } rec_t;

    // configuration
    logic [11:0] limit_reg;
    logic [6:0]  slots_reg;
    logic [PW-1:0] limit_eff;
    logic [NW-1:0] slots_eff;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= tfrt_pkg::LIMIT_RESET;
            slots_reg <= tfrt_pkg::SLOTS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tfrt_pkg::REG_LIMIT) begin
                limit_reg <= pwdata[11:0];
            end else begin
                slots_reg <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == tfrt_pkg::REG_LIMIT) begin
            prdata = {20'd0, limit_reg};
        end else begin
            prdata = {25'd0, slots_reg};
        end
    end

    always_comb begin
        if (32'(limit_reg) > BUFFER_BYTES) begin
            limit_eff = PW'(BUFFER_BYTES);
        end else begin
            limit_eff = PW'(limit_reg);
        end
        if (slots_reg == 7'd0) begin
            slots_eff = NW'(1);
        end else if (32'(slots_reg) > SLOTS) begin
            slots_eff = NW'(SLOTS);
        end else begin
            slots_eff = NW'(slots_reg);
        end
    end

    // state
    tfrt_pkg::state_t state_reg, state_next;

    logic [1:0]  op_reg, op_next;
    logic [31:0] saddr_reg, saddr_next, daddr_reg, daddr_next;
    logic [15:0] sport_reg, sport_next, dport_reg, dport_next;
    logic [31:0] seq_reg, seq_next;
    logic [3:0]  flags_reg, flags_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [15:0] win_reg, win_next;
    logic [16:0] len_reg, len_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [10:0] roff_reg, roff_next;

    logic [NW-1:0] home_reg, home_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [SW-1:0] slot_reg, slot_next;
    rec_t          rec_reg, rec_next;
    logic          open_clr_reg, open_clr_next;

    logic [SW-1:0] seg_slot_reg, seg_slot_next;
    logic [PW-1:0] seg_pos_reg, seg_pos_next;
    logic [PW-1:0] seg_rem_reg, seg_rem_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] clr_end_reg, clr_end_next;

    logic [SLOTS-1:0] valid_reg, valid_next;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [5:0]    m_slot_reg, m_slot_next;
    logic [11:0]   m_fill_reg, m_fill_next;
    logic [7:0]    m_byte_reg, m_byte_next;
    logic          m_fw_reg, m_fw_next;

    // memories
    rec_t          rec_mem [SLOTS];
    rec_t          rec_rd_reg;
    logic          rec_we;
    logic [SW-1:0] rec_waddr, rec_raddr;
    rec_t          rec_wdata;

    logic [8:0]    dat_mem [DEPTH];
    logic [8:0]    dat_rd_reg;
    logic          dat_we;
    logic [AW-1:0] dat_waddr, dat_raddr;
    logic [8:0]    dat_wdata;

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_rd_reg <= rec_mem[rec_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dat_we) begin
            dat_mem[dat_waddr] <= dat_wdata;
        end
        dat_rd_reg <= dat_mem[dat_raddr];
    end

    // hash remainder
    logic          mod_start, mod_done;
    logic [NW-1:0] mod_rem;
    logic [31:0]   hash_sum;

    assign hash_sum = 32'(s_tdata[79:64]) + s_tdata[63:32];

    tfrt_mod_unit #(.NW(NW)) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (hash_sum),
        .divisor   (slots_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // datapath helpers
    logic          accept;
    logic          open_mode;
    logic [NW:0]   jsum;
    logic [SW-1:0] probe_j;
    logic          last_probe;
    logic          key_hit;
    logic [AW-1:0] slot_base;
    logic [AW-1:0] seg_addr;
    logic [AW-1:0] rd_addr;
    logic          pol_fw;
    logic [1:0]    lin_score, win_score;
    logic [33:0]   fill_plus_len;
    logic [31:0]   d_raw, d_pos;
    logic [33:0]   d_plus_len;
    logic          len_nonpos, len_big;

    assign accept    = s_tvalid && s_tready;
    assign open_mode = (op_reg == tfrt_pkg::OP_HEADER) && flags_reg[0] && !flags_reg[1];

    assign jsum       = (NW+1)'(home_reg) + (NW+1)'(idx_reg);
    assign probe_j    = (jsum >= (NW+1)'(slots_eff)) ? SW'(jsum - (NW+1)'(slots_eff))
                                                      : SW'(jsum);
    assign last_probe = (idx_reg == NW'(slots_eff - NW'(1)));

    assign key_hit = valid_reg[slot_reg] && (rec_rd_reg.saddr == saddr_reg) &&
                     (rec_rd_reg.daddr == daddr_reg) && (rec_rd_reg.sport == sport_reg) &&
                     (rec_rd_reg.dport == dport_reg);

    assign slot_base = AW'(slot_reg) * AW'(BUFFER_BYTES);
    assign seg_addr  = AW'(seg_slot_reg) * AW'(BUFFER_BYTES) + AW'(seg_pos_reg);
    assign rd_addr   = slot_base + AW'(roff_reg);

    always_comb begin
        lin_score = 2'd0;
        win_score = 2'd0;
        if (ttl_reg <= tfrt_pkg::TTL_LINUX_MAX) begin
            lin_score = lin_score + 2'd1;
        end else begin
            win_score = win_score + 2'd1;
        end
        if (win_reg == tfrt_pkg::WIN_LINUX) begin
            lin_score = lin_score + 2'd1;
        end else if (win_reg == tfrt_pkg::WIN_WIN_A || win_reg == tfrt_pkg::WIN_WIN_B) begin
            win_score = win_score + 2'd1;
        end
        pol_fw = (lin_score < win_score);
    end

    assign len_nonpos    = len_reg[16] || (len_reg == 17'd0);
    assign len_big       = 34'(len_reg) > 34'(limit_eff);
    assign fill_plus_len = 34'(rec_reg.fill) + 34'(len_reg);
    assign d_raw         = seq_reg - rec_reg.start - 32'd1;
    assign d_pos         = d_raw[31] ? 32'd0 : d_raw;
    assign d_plus_len    = 34'(d_pos) + 34'(len_reg);

    assign s_tready = (state_reg == tfrt_pkg::S_IDLE) && !m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfrt_pkg::S_INIT: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) state_next = tfrt_pkg::S_IDLE;
            end
            tfrt_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        tfrt_pkg::OP_HEADER:  state_next = tfrt_pkg::S_HASH;
                        tfrt_pkg::OP_READ:    state_next = tfrt_pkg::S_HASH;
                        tfrt_pkg::OP_PAYLOAD: state_next = tfrt_pkg::S_PAY_RD;
                        default:              state_next = tfrt_pkg::S_IDLE;
                    endcase
                end
            end
            tfrt_pkg::S_HASH: begin
                if (mod_done) state_next = tfrt_pkg::S_PRB_RD;
            end
            tfrt_pkg::S_PRB_RD: begin
                if (open_mode) begin
                    if (!valid_reg[probe_j]) begin
                        state_next = tfrt_pkg::S_OPEN;
                    end else if (last_probe) begin
                        state_next = tfrt_pkg::S_IDLE;
                    end
                end else begin
                    state_next = tfrt_pkg::S_PRB_CMP;
                end
            end
            tfrt_pkg::S_PRB_CMP: begin
                if (key_hit) begin
                    state_next = (op_reg == tfrt_pkg::OP_HEADER) ? tfrt_pkg::S_HDR_A
                                                                 : tfrt_pkg::S_RD_CHK;
                end else if (last_probe) begin
                    state_next = tfrt_pkg::S_IDLE;
                end else begin
                    state_next = tfrt_pkg::S_PRB_RD;
                end
            end
            tfrt_pkg::S_OPEN: state_next = tfrt_pkg::S_CLEAR;
            tfrt_pkg::S_CLEAR: begin
                if (clr_addr_reg == clr_end_reg) begin
                    state_next = open_clr_reg ? tfrt_pkg::S_IDLE : tfrt_pkg::S_HDR_B;
                end
            end
            tfrt_pkg::S_HDR_A: begin
                if (flags_reg[2] || flags_reg[3] || len_nonpos || len_big) begin
                    state_next = tfrt_pkg::S_IDLE;
                end else if (fill_plus_len > 34'(limit_eff)) begin
                    state_next = tfrt_pkg::S_CLEAR;
                end else begin
                    state_next = tfrt_pkg::S_HDR_B;
                end
            end
            tfrt_pkg::S_HDR_B:   state_next = tfrt_pkg::S_IDLE;
            tfrt_pkg::S_PAY_RD: begin
                state_next = (seg_rem_reg == '0) ? tfrt_pkg::S_IDLE : tfrt_pkg::S_PAY_WR;
            end
            tfrt_pkg::S_PAY_WR:  state_next = tfrt_pkg::S_IDLE;
            tfrt_pkg::S_RD_CHK: begin
                state_next = (32'(roff_reg) >= 32'(rec_reg.fill)) ? tfrt_pkg::S_IDLE
                                                                  : tfrt_pkg::S_RD_DATA;
            end
            tfrt_pkg::S_RD_DATA: state_next = tfrt_pkg::S_IDLE;
            default:             state_next = tfrt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next    = op_reg;
        saddr_next = saddr_reg;
        daddr_next = daddr_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        seq_next   = seq_reg;
        flags_next = flags_reg;
        ttl_next   = ttl_reg;
        win_next   = win_reg;
        len_next   = len_reg;
        pbyte_next = pbyte_reg;
        roff_next  = roff_reg;

        home_next     = home_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        rec_next      = rec_reg;
        open_clr_next = open_clr_reg;
        seg_slot_next = seg_slot_reg;
        seg_pos_next  = seg_pos_reg;
        seg_rem_next  = seg_rem_reg;
        clr_addr_next = clr_addr_reg;
        clr_end_next  = clr_end_reg;
        valid_next    = valid_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_fill_next   = m_fill_reg;
        m_byte_next   = m_byte_reg;
        m_fw_next     = m_fw_reg;

        mod_start = 1'b0;
        rec_we    = 1'b0;
        rec_waddr = slot_reg;
        rec_wdata = rec_reg;
        rec_raddr = slot_reg;
        dat_we    = 1'b0;
        dat_waddr = clr_addr_reg;
        dat_wdata = 9'd0;
        dat_raddr = seg_addr;

        case (state_reg)
            tfrt_pkg::S_INIT: begin
                dat_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            tfrt_pkg::S_IDLE: begin
                if (accept) begin
                    op_next    = s_tuser;
                    saddr_next = s_tdata[31:0];
                    daddr_next = s_tdata[63:32];
                    sport_next = s_tdata[79:64];
                    dport_next = s_tdata[95:80];
                    seq_next   = s_tdata[127:96];
                    flags_next = s_tdata[131:128];
                    ttl_next   = s_tdata[139:132];
                    win_next   = s_tdata[155:140];
                    len_next   = s_tdata[172:156];
                    pbyte_next = s_tdata[180:173];
                    roff_next  = s_tdata[191:181];
                    if (s_tuser == tfrt_pkg::OP_HEADER) seg_rem_next = '0;
                    if (s_tuser == tfrt_pkg::OP_HEADER || s_tuser == tfrt_pkg::OP_READ) begin
                        mod_start = 1'b1;
                    end
                end
            end
            tfrt_pkg::S_HASH: begin
                home_next = mod_rem;
                idx_next  = '0;
            end
            tfrt_pkg::S_PRB_RD: begin
                slot_next = probe_j;
                rec_raddr = probe_j;
                if (open_mode && valid_reg[probe_j]) begin
                    if (last_probe) begin
                        m_valid_next  = 1'b1;
                        m_status_next = tfrt_pkg::ST_TBL_FULL;
                        m_slot_next   = 6'd0;
                        m_fill_next   = 12'd0;
                        m_byte_next   = 8'd0;
                        m_fw_next     = 1'b0;
                    end else begin
                        idx_next = idx_reg + NW'(1);
                    end
                end
            end
            tfrt_pkg::S_PRB_CMP: begin
                if (key_hit) begin
                    rec_next = rec_rd_reg;
                end else if (last_probe) begin
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_NO_FLOW;
                    m_slot_next   = 6'd0;
                    m_fill_next   = 12'd0;
                    m_byte_next   = 8'd0;
                    m_fw_next     = 1'b0;
                end else begin
                    idx_next = idx_reg + NW'(1);
                end
            end
            tfrt_pkg::S_OPEN: begin
                rec_next.saddr  = saddr_reg;
                rec_next.daddr  = daddr_reg;
                rec_next.sport  = sport_reg;
                rec_next.dport  = dport_reg;
                rec_next.start  = seq_reg;
                rec_next.policy = pol_fw;
                rec_next.fill   = '0;
                rec_we          = 1'b1;
                rec_wdata       = rec_next;
                valid_next[slot_reg] = 1'b1;
                clr_addr_next   = slot_base;
                clr_end_next    = slot_base + AW'(BUFFER_BYTES - 1);
                open_clr_next   = 1'b1;
            end
            tfrt_pkg::S_CLEAR: begin
                dat_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == clr_end_reg && open_clr_reg) begin
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_OK;
                    m_slot_next   = 6'(slot_reg);
                    m_fill_next   = 12'd0;
                    m_byte_next   = 8'd0;
                    m_fw_next     = rec_reg.policy;
                end
            end
            tfrt_pkg::S_HDR_A: begin
                m_slot_next = 6'(slot_reg);
                m_byte_next = 8'd0;
                m_fw_next   = rec_reg.policy;
                m_fill_next = 12'(rec_reg.fill);
                if (flags_reg[2] || flags_reg[3]) begin
                    valid_next[slot_reg] = 1'b0;
                    rec_next.fill = '0;
                    rec_we        = 1'b1;
                    rec_wdata     = rec_next;
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_OK;
                    m_fill_next   = 12'd0;
                end else if (len_nonpos) begin
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_BAD_LEN;
                end else if (len_big) begin
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_TOO_BIG;
                end else if (fill_plus_len > 34'(limit_eff)) begin
                    rec_next.fill = '0;
                    clr_addr_next = slot_base;
                    clr_end_next  = slot_base + AW'(BUFFER_BYTES - 1);
                    open_clr_next = 1'b0;
                end
            end
            tfrt_pkg::S_HDR_B: begin
                rec_we        = 1'b1;
                m_valid_next  = 1'b1;
                m_slot_next   = 6'(slot_reg);
                m_byte_next   = 8'd0;
                m_fw_next     = rec_reg.policy;
                if (d_plus_len > 34'(limit_eff)) begin
                    rec_wdata     = rec_reg;
                    m_status_next = tfrt_pkg::ST_TOO_BIG;
                    m_fill_next   = 12'(rec_reg.fill);
                end else begin
                    rec_next.fill = rec_reg.fill + PW'(len_reg);
                    rec_wdata     = rec_next;
                    seg_slot_next = slot_reg;
                    seg_pos_next  = PW'(d_pos);
                    seg_rem_next  = PW'(len_reg);
                    m_status_next = tfrt_pkg::ST_OK;
                    m_fill_next   = 12'(rec_next.fill);
                end
            end
            tfrt_pkg::S_PAY_RD: begin
                rec_raddr = seg_slot_reg;
                dat_raddr = seg_addr;
                if (seg_rem_reg == '0) begin
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_NO_SEG;
                    m_slot_next   = 6'd0;
                    m_fill_next   = 12'd0;
                    m_byte_next   = 8'd0;
                    m_fw_next     = 1'b0;
                end
            end
            tfrt_pkg::S_PAY_WR: begin
                dat_waddr     = seg_addr;
                m_valid_next  = 1'b1;
                m_status_next = tfrt_pkg::ST_OK;
                m_slot_next   = 6'(seg_slot_reg);
                m_fill_next   = 12'(rec_rd_reg.fill);
                m_fw_next     = rec_rd_reg.policy;
                if (rec_rd_reg.policy && dat_rd_reg[8]) begin
                    m_byte_next = dat_rd_reg[7:0];
                end else begin
                    dat_we      = 1'b1;
                    dat_wdata   = {1'b1, pbyte_reg};
                    m_byte_next = pbyte_reg;
                end
                seg_pos_next = seg_pos_reg + PW'(1);
                seg_rem_next = seg_rem_reg - PW'(1);
            end
            tfrt_pkg::S_RD_CHK: begin
                dat_raddr   = rd_addr;
                m_slot_next = 6'(slot_reg);
                m_fill_next = 12'(rec_reg.fill);
                m_fw_next   = rec_reg.policy;
                m_byte_next = 8'd0;
                if (32'(roff_reg) >= 32'(rec_reg.fill)) begin
                    m_valid_next  = 1'b1;
                    m_status_next = tfrt_pkg::ST_PAST_FILL;
                end
            end
            tfrt_pkg::S_RD_DATA: begin
                m_valid_next  = 1'b1;
                m_status_next = tfrt_pkg::ST_OK;
                m_byte_next   = dat_rd_reg[7:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tfrt_pkg::S_INIT;
            clr_addr_reg <= '0;
            valid_reg    <= '0;
            seg_slot_reg <= '0;
            seg_pos_reg  <= '0;
            seg_rem_reg  <= '0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
            open_clr_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            valid_reg    <= valid_next;
            seg_slot_reg <= seg_slot_next;
            seg_pos_reg  <= seg_pos_next;
            seg_rem_reg  <= seg_rem_next;
            m_valid_reg  <= m_valid_next;
            idx_reg      <= idx_next;
            open_clr_reg <= open_clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        saddr_reg    <= saddr_next;
        daddr_reg    <= daddr_next;
        sport_reg    <= sport_next;
        dport_reg    <= dport_next;
        seq_reg      <= seq_next;
        flags_reg    <= flags_next;
        ttl_reg      <= ttl_next;
        win_reg      <= win_next;
        len_reg      <= len_next;
        pbyte_reg    <= pbyte_next;
        roff_reg     <= roff_next;
        home_reg     <= home_next;
        slot_reg     <= slot_next;
        rec_reg      <= rec_next;
        clr_end_reg  <= clr_end_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_fill_reg   <= m_fill_next;
        m_byte_reg   <= m_byte_next;
        m_fw_reg     <= m_fw_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_fw_reg, m_byte_reg, m_fill_reg, m_slot_reg, m_status_reg};

`ifndef NO_ASSERTIONS
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !m_tvalid)
        else $error("transaction accepted while result pending");

    a_seg_in_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_rem_reg != '0) |-> (32'(seg_pos_reg) + 32'(seg_rem_reg) <= BUFFER_BYTES))
        else $error("armed segment runs past flow buffer");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tfrt_pkg::S_IDLE) |-> (!dat_we && !rec_we))
        else $error("memory write while idle");

    a_clear_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tfrt_pkg::S_CLEAR) |-> (clr_addr_reg <= clr_end_reg))
        else $error("clearing sweep past flow buffer");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tfrt_pkg::S_HDR_B) |-> (32'(rec_reg.fill) <= BUFFER_BYTES))
        else $error("flow fill above buffer size");
`endif

endmodule

`default_nettype wire

@@ tb/tcp_flow_reassembly_table_unit_tb.sv @@
// Testbench of tcp_flow_reassembly_table_unit: directed and random streams of headers,
// payload bytes and reads, checked against a flow table predictor. Needs tfrt_pkg and the RTL.
`timescale 1ns / 1ps

module tcp_flow_reassembly_table_unit_tb;

    localparam int NSLOT = 64;
    localparam int NBUF = 2048;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [2:0] ADDR_LIMIT = {tfrt_pkg::REG_LIMIT, 2'b00};
    localparam logic [2:0] ADDR_SLOTS = {tfrt_pkg::REG_SLOTS, 2'b00};
    localparam logic [3:0] F_SYN = 4'h1;
    localparam logic [3:0] F_ACK = 4'h2;
    localparam logic [3:0] F_FIN = 4'h4;
    localparam logic [3:0] F_RST = 4'h8;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
    } flow_key_t;

    typedef struct {
        tfrt_pkg::opcode_t  op;
        flow_key_t          k;
        logic [31:0]        seq;
        logic [3:0]         flags;
        logic [7:0]         ttl;
        logic [15:0]        win;
        logic signed [16:0] len;
        logic [7:0]         pbyte;
        logic [10:0]        roff;
    } seg_item_t;

    typedef struct packed {
        tfrt_pkg::status_t status;
        logic [5:0]        slot;
        logic [11:0]       fill;
        logic [7:0]        data;
        logic              fw;
    } table_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [191:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tcp_flow_reassembly_table_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    // flow table mirror
    logic        tbl_valid [NSLOT];
    flow_key_t   tbl_key [NSLOT];
    logic [31:0] tbl_start [NSLOT];
    logic        tbl_fw [NSLOT];
    logic [11:0] tbl_fill [NSLOT];
    logic [7:0]  buf_mem [NSLOT*NBUF];
    logic        buf_cov [NSLOT*NBUF];
    int          seg_slot, seg_pos, seg_left;
    logic [11:0] cfg_limit;
    logic [6:0]  cfg_slots;

    table_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int opens_seen = 0;
    int cycles = 0;
    int burst_left = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int rx_mode = 0;
    flow_key_t pool [8];

    function automatic int eff_limit();
        return cfg_limit > NBUF ? NBUF : int'(cfg_limit);
    endfunction

    function automatic int eff_slots();
        if (cfg_slots == 0) return 1;
        return cfg_slots > NSLOT ? NSLOT : int'(cfg_slots);
    endfunction

    function automatic int find_slot(flow_key_t k, bit want_free);
        int n, h, j;
        logic [31:0] sum;
        n = eff_slots();
        sum = k.dst + {16'd0, k.sport};
        h = int'(sum % n);
        for (int i = 0; i < n; i++) begin
            j = h + i;
            if (j >= n) j -= n;
            if (want_free) begin
                if (!tbl_valid[j]) return j;
            end else if (tbl_valid[j] && tbl_key[j] == k) begin
                return j;
            end
        end
        return -1;
    endfunction

    function automatic void clear_flow_bytes(int s);
        for (int i = 0; i < NBUF; i++) begin
            buf_mem[s*NBUF+i] = 8'd0;
            buf_cov[s*NBUF+i] = 1'b0;
        end
    endfunction

    function automatic table_result_t make_result(tfrt_pkg::status_t st, int s, logic [7:0] b);
        table_result_t r;
        r.status = st;
        r.data = b;
        if (st == tfrt_pkg::ST_TBL_FULL || st == tfrt_pkg::ST_NO_FLOW ||
            st == tfrt_pkg::ST_NO_SEG) begin
            r.slot = '0;
            r.fill = '0;
            r.fw = 1'b0;
        end else begin
            r.slot = s[5:0];
            r.fill = tbl_fill[s];
            r.fw = tbl_fw[s];
        end
        return r;
    endfunction

    function automatic void reset_table();
        cfg_limit = tfrt_pkg::LIMIT_RESET;
        cfg_slots = tfrt_pkg::SLOTS_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_fill[i] = '0;
            tbl_fw[i] = 1'b0;
            tbl_start[i] = '0;
            clear_flow_bytes(i);
        end
        seg_slot = 0;
        seg_pos = 0;
        seg_left = 0;
    endfunction

    // computes the result of one accepted transaction and updates the mirror
    function automatic void reassembly_step(seg_item_t it);
        int s, lim, plen, lin, wsc, idx;
        logic [31:0] d;
        lim = eff_limit();
        plen = it.len;
        case (it.op)
            tfrt_pkg::OP_HEADER: begin
                seg_left = 0;
                if (it.flags[0] && !it.flags[1]) begin
                    s = find_slot(it.k, 1'b1);
                    if (s < 0) begin
                        pending_results.push_back(make_result(tfrt_pkg::ST_TBL_FULL, 0, 8'd0));
                        return;
                    end
                    lin = 0;
                    wsc = 0;
                    if (it.ttl <= tfrt_pkg::TTL_LINUX_MAX) lin++; else wsc++;
                    if (it.win == tfrt_pkg::WIN_LINUX) lin++;
                    else if (it.win == tfrt_pkg::WIN_WIN_A || it.win == tfrt_pkg::WIN_WIN_B) wsc++;
                    tbl_valid[s] = 1'b1;
                    tbl_key[s] = it.k;
                    tbl_start[s] = it.seq;
                    tbl_fw[s] = lin < wsc;
                    tbl_fill[s] = '0;
                    clear_flow_bytes(s);
                    opens_seen++;
                    pending_results.push_back(make_result(tfrt_pkg::ST_OK, s, 8'd0));
                    return;
                end
                s = find_slot(it.k, 1'b0);
                if (s < 0) begin
                    pending_results.push_back(make_result(tfrt_pkg::ST_NO_FLOW, 0, 8'd0));
                    return;
                end
                if (it.flags[3:2] != 2'b00) begin
                    tbl_valid[s] = 1'b0;
                    tbl_fill[s] = '0;
                    pending_results.push_back(make_result(tfrt_pkg::ST_OK, s, 8'd0));
                    return;
                end
                if (plen <= 0) begin
                    pending_results.push_back(make_result(tfrt_pkg::ST_BAD_LEN, s, 8'd0));
                    return;
                end
                if (plen > lim) begin
                    pending_results.push_back(make_result(tfrt_pkg::ST_TOO_BIG, s, 8'd0));
                    return;
                end
                if (int'(tbl_fill[s]) + plen > lim) begin
                    tbl_fill[s] = '0;
                    clear_flow_bytes(s);
                end
                d = it.seq - tbl_start[s] - 32'd1;
                if (d[31]) d = '0;
                if (longint'(d) + plen > lim) begin
                    pending_results.push_back(make_result(tfrt_pkg::ST_TOO_BIG, s, 8'd0));
                    return;
                end
                seg_slot = s;
                seg_pos = int'(d);
                seg_left = plen;
                tbl_fill[s] = tbl_fill[s] + 12'(plen);
                pending_results.push_back(make_result(tfrt_pkg::ST_OK, s, 8'd0));
            end
            tfrt_pkg::OP_PAYLOAD: begin
                if (seg_left == 0 || seg_pos >= NBUF) begin
                    pending_results.push_back(make_result(tfrt_pkg::ST_NO_SEG, 0, 8'd0));
                    return;
                end
                idx = seg_slot * NBUF + seg_pos;
                if (!(tbl_fw[seg_slot] && buf_cov[idx])) begin
                    buf_mem[idx] = it.pbyte;
                    buf_cov[idx] = 1'b1;
                end
                seg_pos++;
                seg_left--;
                pending_results.push_back(make_result(tfrt_pkg::ST_OK, seg_slot, buf_mem[idx]));
            end
            tfrt_pkg::OP_READ: begin
                s = find_slot(it.k, 1'b0);
                if (s < 0)
                    pending_results.push_back(make_result(tfrt_pkg::ST_NO_FLOW, 0, 8'd0));
                else if (it.roff >= tbl_fill[s])
                    pending_results.push_back(make_result(tfrt_pkg::ST_PAST_FILL, s, 8'd0));
                else
                    pending_results.push_back(make_result(tfrt_pkg::ST_OK, s,
                                                          buf_mem[s*NBUF+it.roff]));
            end
            default: ;
        endcase
    endfunction

    function automatic flow_key_t rand_key();
        flow_key_t k;
        k.src = $urandom;
        k.dst = $urandom;
        k.sport = 16'($urandom);
        k.dport = 16'($urandom);
        return k;
    endfunction

    function automatic seg_item_t rand_item(tfrt_pkg::opcode_t op);
        seg_item_t it;
        it.op = op;
        it.k = rand_key();
        it.seq = $urandom;
        it.flags = 4'($urandom);
        it.ttl = 8'($urandom);
        it.win = 16'($urandom);
        it.len = 17'($urandom);
        it.pbyte = 8'($urandom);
        it.roff = 11'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] flow_start(flow_key_t k);
        int s;
        s = find_slot(k, 1'b0);
        return s >= 0 ? tbl_start[s] : $urandom;
    endfunction

    task automatic send_item(seg_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {it.roff, it.pbyte, it.len, it.win, it.ttl, it.flags, it.seq,
                    it.k.dport, it.k.sport, it.k.dst, it.k.src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        reassembly_step(it);
        if (it.op != tfrt_pkg::OP_NONE) items_sent++;
    endtask

    task automatic send_header(flow_key_t k, logic [31:0] seq, logic [3:0] flags,
                               logic [7:0] ttl, logic [15:0] win, int len);
        seg_item_t it;
        it = rand_item(tfrt_pkg::OP_HEADER);
        it.k = k;
        it.seq = seq;
        it.flags = flags;
        it.ttl = ttl;
        it.win = win;
        it.len = 17'(len);
        send_item(it);
    endtask

    task automatic send_payload(logic [7:0] b);
        seg_item_t it;
        it = rand_item(tfrt_pkg::OP_PAYLOAD);
        it.pbyte = b;
        send_item(it);
    endtask

    task automatic send_read(flow_key_t k, int off);
        seg_item_t it;
        it = rand_item(tfrt_pkg::OP_READ);
        it.k = k;
        it.roff = 11'(off);
        send_item(it);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LIMIT) cfg_limit = value[11:0];
        else cfg_slots = value[6:0];
        @(posedge aclk);
    endtask

    // random well-formed traffic with some noise
    task automatic run_random_traffic(int n_items);
        flow_key_t k;
        int lim, len, off, pick, sent0, nbytes;
        logic [3:0] fl;
        sent0 = items_sent;
        while (items_sent - sent0 < n_items) begin
            k = pool[$urandom_range(0, 7)];
            lim = eff_limit();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_header(k, $urandom, F_SYN | ($urandom_range(0, 1) ? F_FIN : 4'h0),
                            8'($urandom), ($urandom_range(0, 1) ? tfrt_pkg::WIN_WIN_A
                                                                : 16'($urandom)), 0);
            end else if (pick < 55) begin
                len = (lim == 0) ? 1 : $urandom_range(1, lim < 8 ? lim : 8);
                off = (lim > len) ? $urandom_range(0, lim - len) : 0;
                if ($urandom_range(0, 7) == 0) off = lim + $urandom_range(0, 4);
                fl = $urandom_range(0, 1) ? F_ACK : 4'h0;
                send_header(k, flow_start(k) + 32'd1 + off, fl, 8'($urandom), 16'($urandom), len);
                nbytes = len;
                if ($urandom_range(0, 9) == 0) nbytes = len + int'($urandom_range(0, 3)) - 1;
                for (int i = 0; i < nbytes; i++) send_payload(8'($urandom));
            end else if (pick < 80) begin
                send_read(k, $urandom_range(0, 3) == 0 ? $urandom_range(0, NBUF - 1)
                                                        : $urandom_range(0, 12));
            end else if (pick < 86) begin
                send_header(k, $urandom, $urandom_range(0, 1) ? F_FIN : (F_RST | F_ACK),
                            8'($urandom), 16'($urandom), 0);
            end else begin
                send_item(rand_item(tfrt_pkg::opcode_t'($urandom_range(0, 3))));
            end
        end
    endtask

    task automatic test_directed();
        seg_item_t it;
        send_header(pool[0], 32'd1000, F_SYN, 8'd64, tfrt_pkg::WIN_LINUX, 0);
        send_header(pool[1], 32'hFFFF_FFFF, F_SYN, 8'd128, tfrt_pkg::WIN_WIN_A, 0);
        send_header(pool[2], 32'd0, F_SYN | F_FIN, 8'd255, tfrt_pkg::WIN_WIN_B, 0);
        send_header(pool[0], 32'd1001, F_ACK, 8'd0, 16'd0, 3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);
        send_header(pool[0], 32'd1002, 4'h0, 8'd0, 16'd0, 2);
        send_payload(8'hA5);
        send_payload(8'h3C);
        send_header(pool[1], 32'd0, F_ACK, 8'd0, 16'd0, 2);
        send_payload(8'h11);
        send_payload(8'h22);
        send_header(pool[1], 32'hFFFF_FFFF, F_ACK, 8'd0, 16'd0, 1);
        send_payload(8'h99);
        send_payload(8'h77);
        send_read(pool[0], 0);
        send_read(pool[0], 2);
        send_read(pool[0], NBUF - 1);
        send_header(pool[0], 32'd1001, F_ACK, 8'd0, 16'd0, 0);
        send_header(pool[0], 32'd1001, F_ACK, 8'd0, 16'd0, -120);
        send_header(pool[0], 32'd1001, F_ACK, 8'd0, 16'd0, 65535);
        send_header(pool[2], 32'd0, F_RST, 8'd0, 16'd0, 0);
        send_header(pool[2], 32'd0, F_FIN, 8'd0, 16'd0, 0);
        send_read(pool[2], 0);
        send_header(pool[0], 32'd5, F_SYN, 8'd10, tfrt_pkg::WIN_LINUX, 0);
        send_read(pool[0], 1);
        it = rand_item(tfrt_pkg::OP_NONE);
        send_item(it);
        drain_results();
    endtask

    task automatic test_limit_extremes();
        apb_write(ADDR_LIMIT, 32'd0);
        run_random_traffic(40);
        drain_results();
        apb_write(ADDR_LIMIT, 32'd1);
        run_random_traffic(50);
        drain_results();
        apb_write(ADDR_LIMIT, 32'd16);
        run_random_traffic(70);
        drain_results();
        apb_write(ADDR_LIMIT, 32'hFFF);
    endtask

    task automatic test_slot_counts();
        apb_write(ADDR_SLOTS, 32'd1);
        run_random_traffic(50);
        drain_results();
        apb_write(ADDR_SLOTS, 32'd0);
        run_random_traffic(30);
        drain_results();
        apb_write(ADDR_SLOTS, 32'd3);
        run_random_traffic(50);
        drain_results();
        apb_write(ADDR_SLOTS, 32'h7F);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        run_random_traffic(30);
        run_random_traffic(70);
        drain_results();
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_results.size());
            $display("tcp_flow_reassembly_table_unit_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 500;
        end
        if (cycles % 97 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= (cycles % 3 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        table_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = tfrt_pkg::status_t'(m_tdata[2:0]);
            got.slot = m_tdata[8:3];
            got.fill = m_tdata[20:9];
            got.data = m_tdata[28:21];
            got.fw = m_tdata[29];
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result transaction %h", $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) begin
                    errors++;
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.slot != want.slot) begin
                    errors++;
                    $display("%0t slot_index exp %0d got %0d", $time, want.slot, got.slot);
                end
                if (got.fill != want.fill) begin
                    errors++;
                    $display("%0t fill_count exp %0d got %0d", $time, want.fill, got.fill);
                end
                if (got.data != want.data) begin
                    errors++;
                    $display("%0t data_byte exp %h got %h", $time, want.data, got.data);
                end
                if (got.fw != want.fw) begin
                    errors++;
                    $display("%0t first_wins exp %0d got %0d", $time, want.fw, got.fw);
                end
            end
        end
    end

    initial begin
        reset_table();
        for (int i = 0; i < 8; i++) pool[i] = rand_key();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        run_random_traffic(60);
        drain_results();
        test_limit_extremes();
        test_slot_counts();
        test_backpressure();
        drain_results();
        $display("covered %0d transactions, %0d results, %0d flow opens", items_sent,
                 results_seen, opens_seen);
        $display("buffer limits 0..4095 and slot counts 0..127, long output stall included");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tcp_flow_reassembly_table_unit_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("tcp_flow_reassembly_table_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
